[src/ld_pkg.sv]
// ----------------------------------------------------------------------------
// ld_pkg: shared types and constants for the launch detector
// Holds the register file layout, controller states and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ld_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DIR_X    = 3'd0;
  localparam logic [2:0] REG_DIR_Y    = 3'd1;
  localparam logic [2:0] REG_DIR_Z    = 3'd2;
  localparam logic [2:0] REG_MAG      = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE = 3'd4;
  localparam logic [2:0] REG_TIMEOUT  = 3'd5;
  localparam logic [2:0] REG_CLIMB    = 3'd6;

  // register reset values
  localparam logic signed [15:0] RST_DIR_X    = 16'sd0;
  localparam logic signed [15:0] RST_DIR_Y    = 16'sd0;
  localparam logic signed [15:0] RST_DIR_Z    = 16'sd16384;
  localparam logic [15:0]        RST_MAG      = 16'd0;
  localparam logic [7:0]         RST_DEBOUNCE = 8'd3;
  localparam logic [7:0]         RST_TIMEOUT  = 8'd25;
  localparam logic [15:0]        RST_CLIMB    = 16'd160;

  // gravity fallback: below 5.0 m/s^2 use 9.81 m/s^2 (1/256 units)
  localparam logic [15:0] MAG_MIN      = 16'd1280;
  localparam logic [15:0] MAG_FALLBACK = 16'd2511;

  // pad average weights, Q0.16 (0.9 and 0.1 truncated)
  localparam logic signed [16:0] W_OLD = 17'sd58982;
  localparam logic signed [16:0] W_NEW = 17'sd6553;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        mag;
    logic [7:0]         debounce;
    logic [7:0]         timeout;
    logic [15:0]        climb;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_DECIDE,
    ST_AVG_OLD,
    ST_AVG_NEW,
    ST_AVG_WB,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_X,
    MS_Y,
    MS_Z,
    MS_OLD,
    MS_NEW
  } mul_sel_t;

  typedef struct packed {
    logic     load;     // capture input item
    logic     seed;     // first sample seeds pad estimate
    mul_sel_t mul_sel;
    logic     acc_clr;  // accumulator takes product alone
    logic     acc_en;
    logic     est_wr;   // pad estimate takes accumulator >> 16
    logic     out_load; // capture pad altitude into output register
  } cmd_t;

  typedef struct packed {
    logic dot_high;
    logic climb;
  } status_t;

endpackage

`default_nettype wire

[src/ld_regs.sv]
// ----------------------------------------------------------------------------
// ld_regs: configuration register file
// APB-style write/read of the seven detector settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ld_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output ld_pkg::cfg_t      cfg
);
  import ld_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir_x    <= RST_DIR_X;
      cfg.dir_y    <= RST_DIR_Y;
      cfg.dir_z    <= RST_DIR_Z;
      cfg.mag      <= RST_MAG;
      cfg.debounce <= RST_DEBOUNCE;
      cfg.timeout  <= RST_TIMEOUT;
      cfg.climb    <= RST_CLIMB;
    end else if (wr) begin
      unique case (idx)
        REG_DIR_X:    cfg.dir_x    <= pwdata[15:0];
        REG_DIR_Y:    cfg.dir_y    <= pwdata[15:0];
        REG_DIR_Z:    cfg.dir_z    <= pwdata[15:0];
        REG_MAG:      cfg.mag      <= pwdata[15:0];
        REG_DEBOUNCE: cfg.debounce <= pwdata[7:0];
        REG_TIMEOUT:  cfg.timeout  <= pwdata[7:0];
        REG_CLIMB:    cfg.climb    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIR_X:    prdata = {16'd0, cfg.dir_x};
      REG_DIR_Y:    prdata = {16'd0, cfg.dir_y};
      REG_DIR_Z:    prdata = {16'd0, cfg.dir_z};
      REG_MAG:      prdata = {16'd0, cfg.mag};
      REG_DEBOUNCE: prdata = {24'd0, cfg.debounce};
      REG_TIMEOUT:  prdata = {24'd0, cfg.timeout};
      REG_CLIMB:    prdata = {16'd0, cfg.climb};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[src/ld_datapath.sv]
// ----------------------------------------------------------------------------
// ld_datapath: shared multiplier, accumulator and pad estimate
// One 29x17 signed multiplier serves the dot product and the pad average.
// ----------------------------------------------------------------------------
`default_nettype none

module ld_datapath (
  input  wire logic               clk,
  input  wire ld_pkg::cfg_t       cfg,
  input  wire ld_pkg::cmd_t       cmd,
  input  wire logic signed [16:0] accel_x,
  input  wire logic signed [16:0] accel_y,
  input  wire logic signed [16:0] accel_z,
  input  wire logic signed [20:0] altitude,
  output ld_pkg::status_t         status,
  output logic signed [20:0]      pad_altitude
);
  import ld_pkg::*;

  logic signed [16:0] ax, ay, az;
  logic signed [20:0] alt;
  logic signed [28:0] est;        // 1/16 m with 8 fraction bits
  logic signed [47:0] acc;

  logic signed [28:0] op_a;
  logic signed [16:0] op_b;
  logic signed [45:0] prod;
  logic signed [47:0] prod_ext;
  logic signed [47:0] term;

  logic signed [28:0] alt_q;
  logic signed [30:0] climb_diff;
  logic signed [30:0] climb_lim;
  logic [15:0]        mag_eff;
  logic signed [47:0] dot_lim;

  always_comb begin
    unique case (cmd.mul_sel)
      MS_X:    begin op_a = 29'(cfg.dir_x); op_b = ax;    end
      MS_Y:    begin op_a = 29'(cfg.dir_y); op_b = ay;    end
      MS_Z:    begin op_a = 29'(cfg.dir_z); op_b = az;    end
      MS_OLD:  begin op_a = est;            op_b = W_OLD; end
      MS_NEW:  begin op_a = 29'(alt);       op_b = W_NEW; end
      default: begin op_a = '0;             op_b = '0;    end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = 48'(prod);
  // new-sample term weighs alt << 8
  assign term     = (cmd.mul_sel == MS_NEW) ? (prod_ext <<< 8) : prod_ext;

  assign alt_q = {alt, 8'd0};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax  <= accel_x;
      ay  <= accel_y;
      az  <= accel_z;
      alt <= altitude;
    end
    if (cmd.seed) begin
      est <= {altitude, 8'd0};
    end else if (cmd.est_wr) begin
      est <= acc[44:16];  // floor of sum / 65536
    end
    if (cmd.acc_en) begin
      acc <= cmd.acc_clr ? term : acc + term;
    end
    if (cmd.out_load) begin
      pad_altitude <= est[28:8];
    end
  end

  // high tick: dot > (2 * mag) << 14
  assign mag_eff  = (cfg.mag < MAG_MIN) ? MAG_FALLBACK : cfg.mag;
  assign dot_lim  = $signed({17'd0, mag_eff, 15'd0});
  assign status.dot_high = acc > dot_lim;

  // climb: (alt << 8) - est > climb << 8
  assign climb_diff   = 31'(alt_q) - 31'(est);
  assign climb_lim    = $signed({7'd0, cfg.climb, 8'd0});
  assign status.climb = climb_diff > climb_lim;

endmodule

`default_nettype wire

[src/ld_ctrl.sv]
// ----------------------------------------------------------------------------
// ld_ctrl: sequencing state machine and detection state
// Steps the datapath through each tick, runs debounce, arming, timeout and
// launch latch, and owns the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ld_ctrl #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ld_pkg::cfg_t    cfg,
  input  wire ld_pkg::status_t status,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_launched,
  output logic                 out_armed,
  output ld_pkg::cmd_t         cmd
);
  import ld_pkg::*;

  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  state_t state, state_next;

  logic                  pad_valid;
  logic                  armed, armed_next;
  logic                  launched, launched_next;
  logic [COUNT_BITS-1:0] high_count, high_count_next;
  logic [COUNT_BITS-1:0] check_count, check_count_next;
  logic [COUNT_BITS-1:0] high_inc, check_inc;
  logic                  out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (launched) state_next = ST_DONE;
          else if (armed)        state_next = ST_DECIDE;
          else                   state_next = ST_MUL_X;
        end
      end
      ST_MUL_X:   state_next = ST_MUL_Y;
      ST_MUL_Y:   state_next = ST_MUL_Z;
      ST_MUL_Z:   state_next = ST_DECIDE;
      ST_DECIDE:  state_next = (!armed && !status.dot_high) ? ST_AVG_OLD : ST_DONE;
      ST_AVG_OLD: state_next = ST_AVG_NEW;
      ST_AVG_NEW: state_next = ST_AVG_WB;
      ST_AVG_WB:  state_next = ST_DONE;
      ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MS_X;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.seed     = cmd.load && !pad_valid && !launched;
    cmd.out_load = (state == ST_DONE) && out_free;
    unique case (state)
      ST_MUL_X:   begin cmd.mul_sel = MS_X;   cmd.acc_clr = 1'b1; cmd.acc_en = 1'b1; end
      ST_MUL_Y:   begin cmd.mul_sel = MS_Y;   cmd.acc_en = 1'b1; end
      ST_MUL_Z:   begin cmd.mul_sel = MS_Z;   cmd.acc_en = 1'b1; end
      ST_AVG_OLD: begin cmd.mul_sel = MS_OLD; cmd.acc_clr = 1'b1; cmd.acc_en = 1'b1; end
      ST_AVG_NEW: begin cmd.mul_sel = MS_NEW; cmd.acc_en = 1'b1; end
      ST_AVG_WB:  cmd.est_wr = 1'b1;
      default: ;
    endcase
  end

  // detection decision, taken once per tick until the launch is latched
  assign high_inc  = (&high_count)  ? high_count  : high_count  + 1'b1;
  assign check_inc = (&check_count) ? check_count : check_count + 1'b1;

  always_comb begin
    armed_next       = armed;
    launched_next    = launched;
    high_count_next  = high_count;
    check_count_next = check_count;
    if (state == ST_DECIDE) begin
      if (!armed) begin
        if (status.dot_high) begin
          high_count_next = high_inc;
          if (CMP_W'(high_inc) >= CMP_W'(cfg.debounce)) begin
            armed_next       = 1'b1;
            check_count_next = '0;
          end
        end else begin
          high_count_next = '0;
        end
      end else begin
        check_count_next = check_inc;
        if (status.climb) begin
          launched_next = 1'b1;
          armed_next    = 1'b0;
        end else if (CMP_W'(check_inc) >= CMP_W'(cfg.timeout)) begin
          armed_next       = 1'b0;
          high_count_next  = '0;
          check_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pad_valid    <= 1'b0;
      armed        <= 1'b0;
      launched     <= 1'b0;
      high_count   <= '0;
      check_count  <= '0;
      out_valid    <= 1'b0;
      out_launched <= 1'b0;
      out_armed    <= 1'b0;
    end else begin
      state       <= state_next;
      armed       <= armed_next;
      launched    <= launched_next;
      high_count  <= high_count_next;
      check_count <= check_count_next;
      if (cmd.seed) begin
        pad_valid <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid    <= 1'b1;
        out_launched <= launched;
        out_armed    <= armed;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/launch_detector.sv]
// Pad ticks run the dot product and decision, quiet ones also the pad average;
//   armed ticks only the decision, ticks after launch neither. No new tick is
//   taken until the last result is loaded for output; the single shared
//   multiplier takes five products per quiet pad tick (three for the dot, two
//   for the average). Reset (rst, synchronous, active high) clears detection
//   state, the pad seed flag and the output flags, loads register defaults.
// ----------------------------------------------------------------------------
// launch_detector: ground-idle launch detection
// Projects acceleration onto the ground normal, debounces high-g ticks into a
// burn flag, tracks pad altitude and latches launch on a confirmed climb.
// ----------------------------------------------------------------------------
`default_nettype none

module launch_detector #(
  parameter int COUNT_BITS = 8   // width of the debounce and timeout counters
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // sensor tick stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // accel_x[16:0], accel_y[33:17],
                                      // accel_z[50:34], altitude[71:51]
  // status stream, one transfer per tick
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // launched[0], burn_armed[1],
                                      // pad_altitude[22:2], zero[23]
);
  import ld_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  logic               launched;
  logic               burn_armed;
  logic signed [20:0] pad_altitude;

  assign pready = 1'b1;

  ld_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: owns arming, debounce and timeout counters and the output
  // handshake; the datapath only sees commands
  ld_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .status       (status),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_launched (launched),
    .out_armed    (burn_armed),
    .cmd          (cmd)
  );

  // one multiplier, accumulator, pad estimate and compares
  ld_datapath u_dp (
    .clk          (clk),
    .cfg          (cfg),
    .cmd          (cmd),
    .accel_x      ($signed(s_tdata[16:0])),
    .accel_y      ($signed(s_tdata[33:17])),
    .accel_z      ($signed(s_tdata[50:34])),
    .altitude     ($signed(s_tdata[71:51])),
    .status       (status),
    .pad_altitude (pad_altitude)
  );

  assign m_tdata = {1'b0, pad_altitude, burn_armed, launched};

endmodule

`default_nettype wire

[src/ld_checker.sv]
// ----------------------------------------------------------------------------
// ld_checker: port-level checks for the launch detector
// Watches the stream ports and flags ordering or latch violations.
// ----------------------------------------------------------------------------
`default_nettype none

module ld_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  logic seen_launch;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_launch <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[0]) begin
      seen_launch <= 1'b1;
    end
  end

  // launch is sticky across transfers
  a_launch_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && seen_launch) |-> m_tdata[0])
    else $error("launched dropped after launch");

  // burn flag is cleared once launched
  a_not_both: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("launched and burn_armed both set");

  // one tick in flight: no back-to-back input transfers
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a tick is in progress");

  a_out_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind launch_detector ld_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[test/launch_detector_tb.sv]
// ----------------------------------------------------------------------------
// launch_detector_tb: self-checking bench for the launch detector
// Feeds sensor ticks through the input stream, predicts every status transfer
// from a local model of the debounce, pad average, arming and climb logic, and
// compares each one field by field. Register settings change between runs of
// ticks while the block is idle; the last run confirms a launch and checks
// that the block stays frozen afterwards.
// ----------------------------------------------------------------------------
module launch_detector_tb;
  import ld_pkg::*;

  localparam int DRAIN_CYCLES = 20;      // longer than a pad tick takes to report
  localparam int RUN_LIMIT    = 4000000; // time units, far beyond a slow run
  localparam int PHASE_TICKS  = 58;
  localparam int NUM_PHASES   = 9;
  localparam int PRESSURE_PHASE = 2;
  localparam int PRESSURE_HOLD  = 150;   // cycles the status side holds off
  localparam int ALT_MIN = -131072;
  localparam int ALT_MAX = 1048575;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // accel_x[16:0], accel_y[33:17], accel_z[50:34],
                          // altitude[71:51]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // launched[0], burn_armed[1], pad_altitude[22:2],
                          // zero[23]

  // one status transfer as the block reports it
  typedef struct packed {
    logic        launched;
    logic        armed;
    logic [20:0] pad_alt;
  } tick_status_t;

  // --------------------------------------------------------------------------
  // Launch predictor and status scoreboard. Keeps its own copy of the
  // registers and of the detection state; every accepted tick produces one
  // expected status, checked in order against the status stream.
  // --------------------------------------------------------------------------
  class status_scoreboard;
    cfg_t                cfg;
    bit                  pad_valid;
    logic signed [28:0]  pad_est;    // 1/16 m with 8 fraction bits
    bit                  armed;
    logic [7:0]          high_cnt;
    logic [7:0]          chk_cnt;
    bit                  launched;
    tick_status_t        expected_status[$];
    int                  failures;
    int                  ticks;
    int                  arm_events;
    int                  timeouts;

    function new();
      cfg.dir_x    = RST_DIR_X;
      cfg.dir_y    = RST_DIR_Y;
      cfg.dir_z    = RST_DIR_Z;
      cfg.mag      = RST_MAG;
      cfg.debounce = RST_DEBOUNCE;
      cfg.timeout  = RST_TIMEOUT;
      cfg.climb    = RST_CLIMB;
      pad_valid = 1'b0;
      pad_est   = '0;
      armed     = 1'b0;
      high_cnt  = '0;
      chk_cnt   = '0;
      launched  = 1'b0;
    endfunction

    function void flag(string what, longint want, longint got);
      failures++;
      if (failures <= 10)
        $display("mismatch: %s expected %0d got %0d", what, want, got);
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_DIR_X:    cfg.dir_x    = value;
        REG_DIR_Y:    cfg.dir_y    = value;
        REG_DIR_Z:    cfg.dir_z    = value;
        REG_MAG:      cfg.mag      = value;
        REG_DEBOUNCE: cfg.debounce = value[7:0];
        REG_TIMEOUT:  cfg.timeout  = value[7:0];
        REG_CLIMB:    cfg.climb    = value;
        default: ;
      endcase
    endfunction

    function void check_readback(logic [2:0] idx, logic [31:0] rd);
      logic [15:0] want;
      bit          narrow;
      narrow = 1'b0;
      want   = '0;
      case (idx)
        REG_DIR_X:    want = cfg.dir_x;
        REG_DIR_Y:    want = cfg.dir_y;
        REG_DIR_Z:    want = cfg.dir_z;
        REG_MAG:      want = cfg.mag;
        REG_DEBOUNCE: begin
          want   = {8'h00, cfg.debounce};
          narrow = 1'b1;
        end
        REG_TIMEOUT: begin
          want   = {8'h00, cfg.timeout};
          narrow = 1'b1;
        end
        REG_CLIMB:    want = cfg.climb;
        default: ;
      endcase
      if (narrow ? (rd[7:0] != want[7:0]) : (rd[15:0] != want))
        flag($sformatf("register %0d readback", idx), want, rd);
    endfunction

    // highest altitude that cannot count as a climb over the pad
    function longint climb_ceiling();
      return (longint'(pad_est) + longint'(cfg.climb) * 256) >>> 8;
    endfunction

    function longint pad_floor();
      return longint'(pad_est) >>> 8;
    endfunction

    function void note_tick(logic signed [16:0] ax, logic signed [16:0] ay,
                            logic signed [16:0] az, logic signed [20:0] alt);
      longint       dot;
      longint       lim;
      longint       alt_q;
      longint       acc;
      longint       pad_q;
      logic [15:0]  mag;
      tick_status_t st;
      ticks++;
      if (!launched) begin
        alt_q = longint'(alt) * 256;
        dot = longint'($signed(cfg.dir_x)) * longint'(ax)
            + longint'($signed(cfg.dir_y)) * longint'(ay)
            + longint'($signed(cfg.dir_z)) * longint'(az);
        mag = (cfg.mag < MAG_MIN) ? MAG_FALLBACK : cfg.mag;
        lim = longint'(mag) * 32768;   // (2 * mag) << 14
        if (!pad_valid) begin
          pad_est   = 29'(alt_q);
          pad_valid = 1'b1;
        end
        if (!armed) begin
          if (dot > lim) begin
            if (high_cnt != 8'hFF) high_cnt++;
            if (high_cnt >= cfg.debounce) begin
              armed   = 1'b1;
              chk_cnt = '0;
              arm_events++;
            end
          end else begin
            // quiet tick: debounce restarts, pad folds in 0.1 of the altitude
            high_cnt = '0;
            acc = longint'(pad_est) * longint'(W_OLD) + alt_q * longint'(W_NEW);
            pad_est = 29'(acc >>> 16);
          end
        end else begin
          if (chk_cnt != 8'hFF) chk_cnt++;
          if (alt_q - longint'(pad_est) > longint'(cfg.climb) * 256) begin
            launched = 1'b1;
            armed    = 1'b0;
          end else if (chk_cnt >= cfg.timeout) begin
            armed    = 1'b0;
            high_cnt = '0;
            chk_cnt  = '0;
            timeouts++;
          end
        end
      end
      pad_q       = longint'(pad_est) >>> 8;
      st.launched = launched;
      st.armed    = armed;
      st.pad_alt  = pad_q[20:0];
      expected_status.push_back(st);
    endfunction

    function void check_status(logic [23:0] word);
      tick_status_t want;
      if (expected_status.size() == 0) begin
        flag("status transfer with nothing pending", 0, word);
        return;
      end
      want = expected_status.pop_front();
      if (word[0] != want.launched) flag("launched", want.launched, word[0]);
      if (word[1] != want.armed)    flag("burn_armed", want.armed, word[1]);
      if (word[22:2] != want.pad_alt)
        flag("pad_altitude", longint'($signed(want.pad_alt)),
             longint'($signed(word[22:2])));
    endfunction

    function void close_out();
      if (expected_status.size() != 0) begin
        failures++;
        $display("%0d status transfers never arrived", expected_status.size());
      end
    endfunction
  endclass

  status_scoreboard sb;
  bit               tx_done;   // sender has handed over its last tick
  int               settings_used;

  launch_detector i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic int draw_gap(bit idle);
    return idle ? int'($urandom_range(0, 12)) : 0;
  endfunction

  function automatic logic signed [16:0] any_accel();
    int r;
    r = $urandom_range(0, 131071);
    return 17'(r - 65536);
  endfunction

  function automatic logic signed [20:0] clamp_alt(longint v);
    if (v < ALT_MIN) v = ALT_MIN;
    if (v > ALT_MAX) v = ALT_MAX;
    return v[20:0];
  endfunction

  // APB: setup cycle, access cycle, then idle with psel low
  task automatic apb_access(input bit wr, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write, mirror into the predictor, read back
  task automatic set_register(input logic [2:0] idx, input logic [15:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, {16'h0000, value}, rd);
    sb.set_reg(idx, value);
    apb_access(1'b0, idx, 32'h0, rd);
    sb.check_readback(idx, rd);
  endtask

  task automatic apply_settings(input int dx, input int dy, input int dz,
                                input int mag, input int deb, input int tmo,
                                input int climb);
    set_register(REG_DIR_X, dx[15:0]);
    set_register(REG_DIR_Y, dy[15:0]);
    set_register(REG_DIR_Z, dz[15:0]);
    set_register(REG_MAG, mag[15:0]);
    set_register(REG_DEBOUNCE, deb[15:0]);
    set_register(REG_TIMEOUT, tmo[15:0]);
    set_register(REG_CLIMB, climb[15:0]);
    settings_used++;
  endtask

  // Offer one tick after an optional idle gap; returns at the accepting edge.
  // tvalid is only dropped when a gap follows, so back-to-back ticks keep it high.
  task automatic send_tick(input logic signed [16:0] ax, input logic signed [16:0] ay,
                           input logic signed [16:0] az, input logic signed [20:0] alt,
                           input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {alt, az, ay, ax};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(ax, ay, az, alt);
  endtask

  // Random tick shaped by the predicted state: idle ticks mostly push along
  // the ground normal so debounce runs reach arming; armed ticks stay at or
  // below the climb ceiling so the launch is kept for the final run.
  task automatic random_tick(input int gap);
    logic signed [16:0] a[3];
    logic signed [15:0] d[3];
    longint             alt_l;
    int                 m;
    int                 r;
    d[0] = sb.cfg.dir_x;
    d[1] = sb.cfg.dir_y;
    d[2] = sb.cfg.dir_z;
    if (sb.armed && !sb.launched) begin
      for (int k = 0; k < 3; k++) a[k] = any_accel();
      r = $urandom_range(0, 3000);
      alt_l = sb.climb_ceiling();
      if ($urandom_range(0, 3) != 0) alt_l = alt_l - longint'(r);
    end else begin
      if (!sb.launched && $urandom_range(0, 9) < 7) begin
        for (int k = 0; k < 3; k++) begin
          m = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(3000, 12000);
          a[k] = 17'((d[k] < 0) ? -m : m);
        end
      end else begin
        for (int k = 0; k < 3; k++) a[k] = any_accel();
      end
      if (!sb.launched && $urandom_range(0, 6) != 0) begin
        r = $urandom_range(0, 400);
        alt_l = sb.pad_floor() + longint'(r) - 200;
      end else begin
        r = $urandom_range(0, 1179647);
        alt_l = longint'(r) - 131072;
      end
    end
    send_tick(a[0], a[1], a[2], clamp_alt(alt_l), gap);
  endtask

  // Status side: waits out its gap (or the long hold-off), then takes
  // transfers until the sender is done and nothing is pending.
  task automatic collect_status(input int hold, input bit idle);
    int  gap;
    bit  first;
    first = 1'b1;
    while (!tx_done || sb.expected_status.size() != 0) begin
      gap = (first && hold > 0) ? hold : draw_gap(idle);
      first = 1'b0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_status(m_tdata);
    end
  endtask

  // Directed ticks with dir = +z, fallback gravity, debounce 2, timeout 3,
  // climb 160: seeding, field extremes, the dot == limit edge, debounce reset,
  // arming, climb ceiling without launch, timeout, and re-arming.
  task automatic directed_ticks();
    send_tick(0, 0, 0, 1600, draw_gap(1'b1));                    // seeds the pad
    send_tick(-65536, 65535, -65536, ALT_MIN, draw_gap(1'b1));
    send_tick(65535, -65536, 0, ALT_MAX, draw_gap(1'b1));
    send_tick(0, 0, 5022, 1600, draw_gap(1'b1));                 // dot equals limit
    send_tick(0, 0, 5023, 1600, draw_gap(1'b1));                 // just above
    send_tick(0, 0, 0, 1600, draw_gap(1'b1));                    // count restarts
    send_tick(0, 0, 5023, 1600, draw_gap(1'b1));
    send_tick(0, 0, 65535, 1600, draw_gap(1'b1));                // arms
    send_tick(0, 0, 0, clamp_alt(sb.climb_ceiling()), draw_gap(1'b1));
    send_tick(0, 0, 0, ALT_MIN, draw_gap(1'b1));
    send_tick(0, 0, 0, clamp_alt(sb.climb_ceiling()), draw_gap(1'b1)); // times out
    send_tick(0, 0, 65535, 2000, draw_gap(1'b1));
    send_tick(65535, 65535, 65535, 2000, draw_gap(1'b1));        // arms again
    send_tick(0, 0, 0, clamp_alt(sb.climb_ceiling()), draw_gap(1'b1));
    send_tick(0, 0, -65536, clamp_alt(sb.climb_ceiling()), draw_gap(1'b1));
    s_tvalid <= 1'b0;
    tx_done = 1'b1;
  endtask

  // Climb threshold 0: ceiling holds, one step above latches the launch;
  // afterwards every tick must report the frozen state.
  task automatic launch_ticks();
    if (!sb.armed) begin
      send_tick(0, 0, 0, 800, draw_gap(1'b1));
      send_tick(0, 0, 65535, 800, draw_gap(1'b1));               // debounce 1 arms
    end
    send_tick(0, 0, 0, clamp_alt(sb.climb_ceiling()), draw_gap(1'b1));
    send_tick(0, 0, 0, clamp_alt(sb.climb_ceiling() + 1), draw_gap(1'b1));
    for (int i = 0; i < 10; i++) random_tick(draw_gap(1'b1));
    s_tvalid <= 1'b0;
    tx_done = 1'b1;
  endtask

  task automatic configure_phase(input int p);
    int dx, dy, dz;
    case (p)
      0: apply_settings(16384, 0, 0, 1279, 1, 1, 0);              // fallback edge
      1: apply_settings(-16384, 0, 0, 1280, 2, 4, 65535);         // no fallback
      2: apply_settings(0, -16384, 0, 2511, 3, 25, 160);
      3: apply_settings(9459, 9459, 9459, 2000, 4, 10, 1000);     // diagonal normal
      4: apply_settings(-16384, 16384, 16384, 65535, 255, 255, 40000); // never arms
      5: apply_settings(0, 0, 0, 5000, 2, 2, 300);                // zero normal
      default: begin
        dx = $urandom_range(0, 32768);
        dy = $urandom_range(0, 32768);
        dz = $urandom_range(0, 32768);
        apply_settings(dx - 16384, dy - 16384, dz - 16384, $urandom_range(0, 3000),
                       $urandom_range(1, 6), $urandom_range(1, 30),
                       $urandom_range(0, 2000));
      end
    endcase
  endtask

  task automatic run_phase(input int n, input int hold);
    bit tx_idle;
    bit rx_idle;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    tx_done = 1'b0;
    fork
      begin
        for (int i = 0; i < n; i++) random_tick(draw_gap(tx_idle));
        s_tvalid <= 1'b0;
        tx_done = 1'b1;
      end
      collect_status(hold, rx_idle);
    join
  endtask

  initial begin
    sb = new();
    settings_used = 0;
    tx_done  = 1'b0;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    m_tready <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed run
    apply_settings(0, 0, 16384, 0, 2, 3, 160);
    fork
      directed_ticks();
      collect_status(0, 1'b1);
    join

    // random runs, one register setting each; one run stalls the status side
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure_phase(p);
      run_phase(PHASE_TICKS, (p == PRESSURE_PHASE) ? PRESSURE_HOLD : 0);
    end

    // launch and frozen ticks
    apply_settings(0, 0, 16384, 1279, 1, 255, 0);
    tx_done = 1'b0;
    fork
      launch_ticks();
      collect_status(0, 1'b1);
    join

    // drain: any further status transfer is unexpected
    m_tready <= 1'b1;
    repeat (DRAIN_CYCLES) begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_status(m_tdata);
    end
    sb.close_out();

    $display("covered %0d ticks under %0d register settings: %0d arm events, %0d timeouts",
             sb.ticks, settings_used, sb.arm_events, sb.timeouts);
    $display("launch latched: %0d, failed checks: %0d", sb.launched, sb.failures);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
